// ===== src/shc_pkg.sv =====
// shared types, constants and helpers of the halfspace constraint generator
package shc_pkg;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_POSE_X    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POSE_Y    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POLY_RNG  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACT_RNG   = 2'd3;

  localparam logic [1:0] FUNC_SAMPLE    = 2'd0;
  localparam logic [1:0] FUNC_HALFSPACE = 2'd1;
  localparam logic [1:0] FUNC_MEAN      = 2'd2;

  localparam logic [30:0] POLY_RNG_RST = 31'd327680;
  localparam logic [30:0] ACT_RNG_RST  = 31'd655360;

  // sqrt(2) in Q30
  localparam logic [30:0] SQRT2_Q30 = 31'd1518500250;

  localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] Q_MIN = 32'sh80000000;

  // root of a 66-bit radicand, one result bit per stage
  localparam int SQ_RAD_W  = 66;
  localparam int SQ_ROOT_W = 33;
  localparam int SQ_REM_W  = 36;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] off;
  } item_t;

  typedef struct packed {
    item_t       item;
    logic [32:0] ux;
    logic [32:0] uy;
    logic        nx;
    logic        ny;
  } sq_pl_t;

  typedef struct packed {
    item_t       item;
    logic        nx;
    logic        ny;
    logic [32:0] d;
  } cd_pl_t;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] a1;
    logic signed [31:0] a2;
    logic [30:0]        distance;
    logic               active;
    logic               deg;
  } ln_t;

  typedef struct packed {
    ln_t                ln;
    logic signed [31:0] b;
    logic               negl;
    logic               negr;
    logic               zl;
    logic               zr;
    logic               ovfl;
    logic               ovfr;
  } ed_pl_t;

  function automatic logic signed [31:0] sat66(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'(Q_MAX)) r = Q_MAX;
    else if (v < 66'(Q_MIN)) r = Q_MIN;
    else r = v[31:0];
    return r;
  endfunction

  // signed saturated quotient from magnitude quotient and flags
  function automatic logic signed [31:0] edge_sat(input logic [31:0] q, input logic neg,
                                                  input logic zero, input logic ovf,
                                                  input logic den_zero);
    logic signed [31:0] r;
    if (den_zero) r = zero ? 32'sd0 : (neg ? Q_MIN : Q_MAX);
    else if (ovf) r = neg ? Q_MIN : Q_MAX;
    else if (neg) r = (q > 32'h80000000) ? Q_MIN : $signed(32'd0 - q);
    else r = q[31] ? Q_MAX : $signed(q);
    return r;
  endfunction

endpackage

// ===== src/shc_if.sv =====
// valid/ready channel interfaces for items and results
interface shc_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_y;
  logic signed [31:0] offset_in;
  modport source(output valid, func, coord_x, coord_y, offset_in, input ready);
  modport sink(input valid, func, coord_x, coord_y, offset_in, output ready);
endinterface

interface shc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] coef_a1;
  logic signed [31:0] coef_a2;
  logic signed [31:0] offset_b;
  logic [30:0]        dist_out;
  logic signed [31:0] y_at_left;
  logic signed [31:0] y_at_right;
  logic               is_top;
  logic               is_active;
  logic               degenerate;
  modport source(output valid, coef_a1, coef_a2, offset_b, dist_out, y_at_left, y_at_right,
                 is_top, is_active, degenerate, input ready);
  modport sink(input valid, coef_a1, coef_a2, offset_b, dist_out, y_at_left, y_at_right,
               is_top, is_active, degenerate, output ready);
endinterface

// ===== src/shc_sqrt_pipe.sv =====
// pipelined integer square root, one root bit per stage
module shc_sqrt_pipe import shc_pkg::*; #(
  parameter int PW = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [SQ_RAD_W-1:0]  in_rad,
  input  logic [PW-1:0]        in_pl,
  output logic                 out_valid,
  output logic [SQ_ROOT_W-1:0] out_root,
  output logic [PW-1:0]        out_pl
);

  logic [SQ_REM_W-1:0]  rem_r  [SQ_ROOT_W];
  logic [SQ_ROOT_W-1:0] root_r [SQ_ROOT_W];
  logic [SQ_RAD_W-1:0]  rad_r  [SQ_ROOT_W];
  logic                 v_r    [SQ_ROOT_W];
  logic [PW-1:0]        pl_r   [SQ_ROOT_W];

  for (genvar s = 0; s < SQ_ROOT_W; s++) begin : g_st
    logic [SQ_REM_W-1:0]  rem_in, shf, trial, rem_nxt;
    logic [SQ_ROOT_W-1:0] root_in, root_nxt;
    logic [SQ_RAD_W-1:0]  rad_in;
    logic                 v_in, bit_ok;
    logic [PW-1:0]        pl_in;

    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = in_rad;
      assign v_in    = in_valid;
      assign pl_in   = in_pl;
    end else begin : g_next
      assign rem_in  = rem_r[s-1];
      assign root_in = root_r[s-1];
      assign rad_in  = rad_r[s-1];
      assign v_in    = v_r[s-1];
      assign pl_in   = pl_r[s-1];
    end

    always_comb begin
      shf      = {rem_in[SQ_REM_W-3:0], rad_in[SQ_RAD_W-1 -: 2]};
      trial    = {1'b0, root_in, 2'b01};
      bit_ok   = shf >= trial;
      rem_nxt  = bit_ok ? shf - trial : shf;
      root_nxt = {root_in[SQ_ROOT_W-2:0], bit_ok};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]  <= rem_nxt;
        root_r[s] <= root_nxt;
        rad_r[s]  <= rad_in << 2;
        pl_r[s]   <= pl_in;
      end
    end
  end

  assign out_valid = v_r[SQ_ROOT_W-1];
  assign out_root  = root_r[SQ_ROOT_W-1];
  assign out_pl    = pl_r[SQ_ROOT_W-1];

endmodule

// ===== src/shc_div_pipe.sv =====
// two-lane pipelined restoring divider, one quotient bit per stage
module shc_div_pipe #(
  parameter int NUM_W  = 64,
  parameter int DEN_W  = 32,
  parameter int Q_BITS = 32,
  parameter int PW     = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  num0,
  input  logic [NUM_W-1:0]  num1,
  input  logic [DEN_W-1:0]  den0,
  input  logic [DEN_W-1:0]  den1,
  input  logic [PW-1:0]     in_pl,
  output logic              out_valid,
  output logic [Q_BITS-1:0] quo0,
  output logic [Q_BITS-1:0] quo1,
  output logic [PW-1:0]     out_pl
);

  // remainder stays below the divisor when num < den * 2^Q_BITS
  localparam int RW = DEN_W + 1;

  logic [NUM_W-1:0]  num_l  [2];
  logic [DEN_W-1:0]  den_l  [2];
  logic [RW-1:0]     rem_r  [2][Q_BITS];
  logic [Q_BITS-1:0] lo_r   [2][Q_BITS];
  logic [Q_BITS-1:0] quo_r  [2][Q_BITS];
  logic [DEN_W-1:0]  den_r  [2][Q_BITS];
  logic              v_r    [Q_BITS];
  logic [PW-1:0]     pl_r   [Q_BITS];

  assign num_l[0] = num0;
  assign num_l[1] = num1;
  assign den_l[0] = den0;
  assign den_l[1] = den1;

  for (genvar s = 0; s < Q_BITS; s++) begin : g_st
    for (genvar l = 0; l < 2; l++) begin : g_ln
      logic [RW-1:0]     rem_in, shf, rem_nxt;
      logic [Q_BITS-1:0] lo_in, quo_in;
      logic [DEN_W-1:0]  den_in;
      logic [NUM_W-1:0]  hi;
      logic              bit_ok;

      assign hi = num_l[l] >> Q_BITS;

      if (s == 0) begin : g_first
        assign rem_in = hi[RW-1:0];
        assign lo_in  = num_l[l][Q_BITS-1:0];
        assign quo_in = '0;
        assign den_in = den_l[l];
      end else begin : g_next
        assign rem_in = rem_r[l][s-1];
        assign lo_in  = lo_r[l][s-1];
        assign quo_in = quo_r[l][s-1];
        assign den_in = den_r[l][s-1];
      end

      always_comb begin
        shf     = {rem_in[RW-2:0], lo_in[Q_BITS-1]};
        bit_ok  = shf >= {1'b0, den_in};
        rem_nxt = bit_ok ? shf - {1'b0, den_in} : shf;
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[l][s] <= rem_nxt;
          lo_r[l][s]  <= lo_in << 1;
          quo_r[l][s] <= {quo_in[Q_BITS-2:0], bit_ok};
          den_r[l][s] <= den_in;
        end
      end
    end

    if (s == 0) begin : g_vfirst
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[s] <= 1'b0;
        end else if (en) begin
          v_r[s] <= in_valid;
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          pl_r[s] <= in_pl;
        end
      end
    end else begin : g_vnext
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[s] <= 1'b0;
        end else if (en) begin
          v_r[s] <= v_r[s-1];
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          pl_r[s] <= pl_r[s-1];
        end
      end
    end
  end

  assign out_valid = v_r[Q_BITS-1];
  assign quo0      = quo_r[0][Q_BITS-1];
  assign quo1      = quo_r[1][Q_BITS-1];
  assign out_pl    = pl_r[Q_BITS-1];

endmodule

// ===== src/sample_halfspace_constraint_gen.sv =====
// top level: halfspace constraints from obstacle samples, external halfspaces and means
//
// Items arrive on in_ch (valid/ready) and each gives exactly one result on out_ch.
// func selects an obstacle sample, an external halfspace or an obstacle mean check.
// Pose and ranges come from the cfg write port (index 0..3) and must only be
// written while no item is in flight.
// The datapath is one pipeline with valid bits: 4 front stages (difference,
// magnitude, square, sum), 33 square-root stages, FRAC_BITS+1 stages of the
// coefficient divider, 6 stages for b and the edge numerators, 32 stages of the
// edge divider and the output register. Values are Q16.16 at the default FRAC_BITS.
// Throughput is one item per cycle unless an out_ch stall freezes the pipeline;
// every stage is one root or divider step or one multiply; nothing iterates in place.
// When out_ch stalls the output register holds its result; the pipeline keeps
// moving while its last stage is empty and freezes otherwise, so in_ch.ready
// drops only when a finished result is waiting behind the held one.
// Reset (rst_n low, synchronous) clears all valid bits and loads the register
// reset values; no result is lost or repeated across a stall.
module sample_halfspace_constraint_gen import shc_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  shc_in_if.sink               in_ch,
  shc_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [31:0]          cfg_wdata
);

  localparam int NUM_W   = 33 + FRAC_BITS;
  localparam int QC      = FRAC_BITS + 1;
  localparam int EPS_RAW = ((1 << FRAC_BITS) + 50000) / 100000;
  localparam int EPS     = (EPS_RAW < 1) ? 1 : EPS_RAW;
  localparam logic signed [31:0] EPS_Q = 32'(EPS);

  function automatic logic signed [31:0] clamp_eps(input logic signed [31:0] a);
    logic signed [31:0] r;
    r = (a > -EPS_Q && a < EPS_Q) ? EPS_Q : a;
    return r;
  endfunction

  // configuration registers
  logic signed [31:0] pose_x_r, pose_y_r;
  logic [30:0]        prange_r, arange_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pose_x_r <= '0;
      pose_y_r <= '0;
      prange_r <= POLY_RNG_RST;
      arange_r <= ACT_RNG_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_POSE_X:   pose_x_r <= cfg_wdata;
        CFG_POSE_Y:   pose_y_r <= cfg_wdata;
        CFG_POLY_RNG: prange_r <= cfg_wdata[30:0];
        CFG_ACT_RNG:  arange_r <= cfg_wdata[30:0];
      endcase
    end
  end

  // window edges follow the configuration continuously
  logic [61:0]        wprod_r;
  logic [62:0]        wsum;
  logic signed [33:0] w_s;
  logic signed [31:0] xl_r, xl_nxt, xr_r, xr_nxt;

  always_comb begin
    wsum   = {1'b0, wprod_r} + 63'(64'd1 << 29);
    w_s    = $signed({1'b0, wsum[62:30]});
    xl_nxt = sat66(66'(34'(pose_x_r) - w_s));
    xr_nxt = sat66(66'(34'(pose_x_r) + w_s));
  end

  always_ff @(posedge clk) begin
    wprod_r <= prange_r * SQRT2_Q30;
    xl_r    <= xl_nxt;
    xr_r    <= xr_nxt;
  end

  // pipeline control
  logic out_valid_r, out_load, en, ed_v;

  assign out_load    = !out_valid_r || out_ch.ready;
  assign en          = out_load || !ed_v;
  assign in_ch.ready = en;

  // stage a: differences to the pose
  logic               a_v_r;
  item_t              a_item_r;
  logic signed [32:0] a_dx_r, a_dy_r, a_dx_nxt, a_dy_nxt;

  assign a_dx_nxt = 33'(in_ch.coord_x) - 33'(pose_x_r);
  assign a_dy_nxt = 33'(in_ch.coord_y) - 33'(pose_y_r);

  // stage b: magnitudes
  logic        b_v_r;
  item_t       b_item_r;
  logic [32:0] b_ux_r, b_uy_r, b_ux_nxt, b_uy_nxt;
  logic        b_nx_r, b_ny_r;

  assign b_ux_nxt = a_dx_r[32] ? 33'(-a_dx_r) : 33'(a_dx_r);
  assign b_uy_nxt = a_dy_r[32] ? 33'(-a_dy_r) : 33'(a_dy_r);

  // stage c: squares
  logic        c_v_r;
  sq_pl_t      c_pl_r;
  logic [65:0] c_sx_r, c_sy_r, c_sx_nxt, c_sy_nxt;

  assign c_sx_nxt = b_ux_r * b_ux_r;
  assign c_sy_nxt = b_uy_r * b_uy_r;

  // stage d: sum of squares
  logic        d_v_r;
  sq_pl_t      d_pl_r;
  logic [65:0] d_sum_r, d_sum_nxt;

  assign d_sum_nxt = c_sx_r + c_sy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_ch.valid;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
      d_v_r <= c_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_item_r.func <= in_ch.func;
      a_item_r.cx   <= in_ch.coord_x;
      a_item_r.cy   <= in_ch.coord_y;
      a_item_r.off  <= in_ch.offset_in;
      a_dx_r        <= a_dx_nxt;
      a_dy_r        <= a_dy_nxt;
      b_item_r      <= a_item_r;
      b_ux_r        <= b_ux_nxt;
      b_uy_r        <= b_uy_nxt;
      b_nx_r        <= a_dx_r[32];
      b_ny_r        <= a_dy_r[32];
      c_pl_r        <= '{item: b_item_r, ux: b_ux_r, uy: b_uy_r, nx: b_nx_r, ny: b_ny_r};
      c_sx_r        <= c_sx_nxt;
      c_sy_r        <= c_sy_nxt;
      d_pl_r        <= c_pl_r;
      d_sum_r       <= d_sum_nxt;
    end
  end

  // distance
  logic                 sq_v;
  logic [SQ_ROOT_W-1:0] sq_d;
  sq_pl_t               sq_pl;

  shc_sqrt_pipe #(.PW($bits(sq_pl_t))) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (d_v_r),
    .in_rad   (d_sum_r),
    .in_pl    (d_pl_r),
    .out_valid(sq_v),
    .out_root (sq_d),
    .out_pl   (sq_pl)
  );

  // unit vector: |dx| * 2^F / d, known to stay at or below 2^F
  logic             cd_v;
  logic [QC-1:0]    cd_q0, cd_q1;
  cd_pl_t           cd_pl;
  logic [NUM_W-1:0] cd_n0, cd_n1;

  assign cd_n0 = {sq_pl.ux, {FRAC_BITS{1'b0}}};
  assign cd_n1 = {sq_pl.uy, {FRAC_BITS{1'b0}}};

  shc_div_pipe #(
    .NUM_W (NUM_W),
    .DEN_W (33),
    .Q_BITS(QC),
    .PW    ($bits(cd_pl_t))
  ) u_coef_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (sq_v),
    .num0     (cd_n0),
    .num1     (cd_n1),
    .den0     (sq_d),
    .den1     (sq_d),
    .in_pl    (cd_pl_t'{item: sq_pl.item, nx: sq_pl.nx, ny: sq_pl.ny, d: sq_d}),
    .out_valid(cd_v),
    .quo0     (cd_q0),
    .quo1     (cd_q1),
    .out_pl   (cd_pl)
  );

  // stage e: coefficients, distance, activity
  logic               e_v_r;
  ln_t                e_ln_r, e_ln_nxt;
  logic signed [31:0] e_cx_r, e_cy_r, e_off_r;
  logic [30:0]        e_dsat;

  always_comb begin
    e_dsat   = (cd_pl.d[32:31] != 2'b00) ? 31'h7fffffff : cd_pl.d[30:0];
    e_ln_nxt = '0;
    e_ln_nxt.func = cd_pl.item.func;
    unique case (cd_pl.item.func)
      FUNC_SAMPLE: begin
        e_ln_nxt.distance = e_dsat;
        if (cd_pl.d == '0) begin
          // sample at the pose
          e_ln_nxt.deg = 1'b1;
        end else begin
          e_ln_nxt.a1 = cd_pl.nx ? $signed(32'd0 - 32'(cd_q0)) : $signed(32'(cd_q0));
          e_ln_nxt.a2 = cd_pl.ny ? $signed(32'd0 - 32'(cd_q1)) : $signed(32'(cd_q1));
        end
      end
      FUNC_HALFSPACE: begin
        e_ln_nxt.a1 = clamp_eps(cd_pl.item.cx);
        e_ln_nxt.a2 = clamp_eps(cd_pl.item.cy);
      end
      FUNC_MEAN: begin
        e_ln_nxt.distance = e_dsat;
        e_ln_nxt.active   = cd_pl.d <= {2'b00, arange_r};
      end
      default: ;
    endcase
  end

  // stage f: products
  logic               f_v_r;
  ln_t                f_ln_r;
  logic signed [31:0] f_off_r;
  logic signed [63:0] f_p1_r, f_p2_r, f_pl_r, f_pr_r;
  logic signed [63:0] f_p1_nxt, f_p2_nxt, f_pl_nxt, f_pr_nxt;

  assign f_p1_nxt = e_ln_r.a1 * e_cx_r;
  assign f_p2_nxt = e_ln_r.a2 * e_cy_r;
  assign f_pl_nxt = e_ln_r.a1 * xl_r;
  assign f_pr_nxt = e_ln_r.a1 * xr_r;

  // stage g: right-hand side
  logic               g_v_r;
  ln_t                g_ln_r;
  logic signed [31:0] g_b_r, g_b_nxt;
  logic signed [63:0] g_pl_r, g_pr_r;
  logic signed [64:0] g_sum, g_shr;
  logic signed [65:0] g_bb;

  always_comb begin
    g_sum = 65'(f_p1_r) + 65'(f_p2_r);
    g_shr = g_sum >>> FRAC_BITS;
    g_bb  = 66'(g_shr) - 66'(f_off_r);
    if (f_ln_r.func == FUNC_SAMPLE) g_b_nxt = sat66(g_bb);
    else if (f_ln_r.func == FUNC_HALFSPACE) g_b_nxt = f_off_r;
    else g_b_nxt = '0;
  end

  // stage h: edge numerators b * 2^F - a1 * x_edge
  logic               h_v_r;
  ln_t                h_ln_r;
  logic signed [31:0] h_b_r;
  logic signed [63:0] h_nl_r, h_nr_r, h_bsh, h_nl_nxt, h_nr_nxt;

  always_comb begin
    h_bsh    = 64'(g_b_r) <<< FRAC_BITS;
    h_nl_nxt = h_bsh - g_pl_r;
    h_nr_nxt = h_bsh - g_pr_r;
  end

  // stage i: magnitudes and signs
  logic               i_v_r;
  ln_t                i_ln_r;
  logic signed [31:0] i_b_r;
  logic [63:0]        i_ml_r, i_mr_r;
  logic               i_negl_r, i_negr_r, i_zl_r, i_zr_r;
  logic [31:0]        i_ua2_r;

  // stage j: quotient overflow beyond 32 bits
  logic        j_v_r;
  ed_pl_t      j_pl_r;
  logic [63:0] j_ml_r, j_mr_r;
  logic [31:0] j_ua2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r <= 1'b0;
      f_v_r <= 1'b0;
      g_v_r <= 1'b0;
      h_v_r <= 1'b0;
      i_v_r <= 1'b0;
      j_v_r <= 1'b0;
    end else if (en) begin
      e_v_r <= cd_v;
      f_v_r <= e_v_r;
      g_v_r <= f_v_r;
      h_v_r <= g_v_r;
      i_v_r <= h_v_r;
      j_v_r <= i_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_ln_r   <= e_ln_nxt;
      e_cx_r   <= cd_pl.item.cx;
      e_cy_r   <= cd_pl.item.cy;
      e_off_r  <= cd_pl.item.off;
      f_ln_r   <= e_ln_r;
      f_off_r  <= e_off_r;
      f_p1_r   <= f_p1_nxt;
      f_p2_r   <= f_p2_nxt;
      f_pl_r   <= f_pl_nxt;
      f_pr_r   <= f_pr_nxt;
      g_ln_r   <= f_ln_r;
      g_b_r    <= g_b_nxt;
      g_pl_r   <= f_pl_r;
      g_pr_r   <= f_pr_r;
      h_ln_r   <= g_ln_r;
      h_b_r    <= g_b_r;
      h_nl_r   <= h_nl_nxt;
      h_nr_r   <= h_nr_nxt;
      i_ln_r   <= h_ln_r;
      i_b_r    <= h_b_r;
      i_ml_r   <= h_nl_r[63] ? 64'(-h_nl_r) : 64'(h_nl_r);
      i_mr_r   <= h_nr_r[63] ? 64'(-h_nr_r) : 64'(h_nr_r);
      i_negl_r <= h_nl_r[63];
      i_negr_r <= h_nr_r[63];
      i_zl_r   <= h_nl_r == '0;
      i_zr_r   <= h_nr_r == '0;
      i_ua2_r  <= h_ln_r.a2[31] ? 32'(-h_ln_r.a2) : 32'(h_ln_r.a2);
      j_pl_r.ln   <= i_ln_r;
      j_pl_r.b    <= i_b_r;
      // quotient sign: numerator sign flipped by a negative a2
      j_pl_r.negl <= i_negl_r ^ i_ln_r.a2[31];
      j_pl_r.negr <= i_negr_r ^ i_ln_r.a2[31];
      j_pl_r.zl   <= i_zl_r;
      j_pl_r.zr   <= i_zr_r;
      j_pl_r.ovfl <= i_ml_r[63:32] >= i_ua2_r;
      j_pl_r.ovfr <= i_mr_r[63:32] >= i_ua2_r;
      j_ml_r   <= i_ml_r;
      j_mr_r   <= i_mr_r;
      j_ua2_r  <= i_ua2_r;
    end
  end

  // edge y values
  logic [31:0] ed_q0, ed_q1;
  ed_pl_t      ed_pl;

  shc_div_pipe #(
    .NUM_W (64),
    .DEN_W (32),
    .Q_BITS(32),
    .PW    ($bits(ed_pl_t))
  ) u_edge_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (j_v_r),
    .num0     (j_ml_r),
    .num1     (j_mr_r),
    .den0     (j_ua2_r),
    .den1     (j_ua2_r),
    .in_pl    (j_pl_r),
    .out_valid(ed_v),
    .quo0     (ed_q0),
    .quo1     (ed_q1),
    .out_pl   (ed_pl)
  );

  // output register
  logic               o_line, o_a2z;
  logic signed [31:0] o_a1_r, o_a2_r, o_b_r, o_yl_r, o_yr_r, o_yl_nxt, o_yr_nxt;
  logic [30:0]        o_dist_r;
  logic               o_top_r, o_act_r, o_deg_r, o_top_nxt, o_deg_nxt;

  always_comb begin
    o_line    = ed_pl.ln.func == FUNC_SAMPLE || ed_pl.ln.func == FUNC_HALFSPACE;
    o_a2z     = ed_pl.ln.a2 == '0;
    o_yl_nxt  = '0;
    o_yr_nxt  = '0;
    o_top_nxt = 1'b0;
    o_deg_nxt = ed_pl.ln.deg;
    if (o_line) begin
      o_yl_nxt  = edge_sat(ed_q0, ed_pl.negl, ed_pl.zl, ed_pl.ovfl, o_a2z);
      o_yr_nxt  = edge_sat(ed_q1, ed_pl.negr, ed_pl.zr, ed_pl.ovfr, o_a2z);
      o_top_nxt = ed_pl.ln.a2 > 32'sd0;
      o_deg_nxt = ed_pl.ln.deg | o_a2z;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= ed_v;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && ed_v) begin
      o_a1_r   <= ed_pl.ln.a1;
      o_a2_r   <= ed_pl.ln.a2;
      o_b_r    <= ed_pl.b;
      o_dist_r <= ed_pl.ln.distance;
      o_yl_r   <= o_yl_nxt;
      o_yr_r   <= o_yr_nxt;
      o_top_r  <= o_top_nxt;
      o_act_r  <= ed_pl.ln.active;
      o_deg_r  <= o_deg_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.coef_a1    = o_a1_r;
  assign out_ch.coef_a2    = o_a2_r;
  assign out_ch.offset_b   = o_b_r;
  assign out_ch.dist_out   = o_dist_r;
  assign out_ch.y_at_left  = o_yl_r;
  assign out_ch.y_at_right = o_yr_r;
  assign out_ch.is_top     = o_top_r;
  assign out_ch.is_active  = o_act_r;
  assign out_ch.degenerate = o_deg_r;

endmodule

// ===== verif/tb.sv =====
// self-checking testbench of the halfspace constraint generator
`timescale 1ns / 1ps

module tb;
  import shc_pkg::*;

  localparam int FRAC = 16;
  localparam int PIPE_LAT = FRAC + 77;

  typedef logic signed [95:0] wide_t;
  localparam wide_t W_MAX = 96'sd2147483647;
  localparam wide_t W_MIN = -96'sd2147483648;

  typedef struct {
    logic signed [31:0] a1;
    logic signed [31:0] a2;
    logic signed [31:0] b;
    logic [30:0]        distance;
    logic signed [31:0] yl;
    logic signed [31:0] yr;
    logic               top;
    logic               active;
    logic               deg;
  } constraint_t;

  logic clk;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [31:0]          cfg_wdata;

  shc_in_if  in_ch();
  shc_out_if out_ch();

  sample_halfspace_constraint_gen #(.FRAC_BITS(FRAC)) u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  // predictor copy of the registers
  logic signed [31:0] pose_x_q, pose_y_q;
  logic [30:0]        poly_rng_q, act_rng_q;

  constraint_t pending_results[$];
  int src_idle_pct, snk_idle_pct;
  int n_errors, n_sent, n_checked, n_degenerate, n_active;

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  initial begin
    #5ms;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic wide_t sat_q(wide_t v);
    if (v > W_MAX) return W_MAX;
    if (v < W_MIN) return W_MIN;
    return v;
  endfunction

  function automatic wide_t div_sat(wide_t num, wide_t den, inout logic deg);
    wide_t q;
    if (den == 0) begin
      deg = 1'b1;
      return num > 0 ? W_MAX : (num < 0 ? W_MIN : 0);
    end
    q = (num < 0 ? -num : num) / (den < 0 ? -den : den);
    if ((num < 0) != (den < 0)) return q > -W_MIN ? W_MIN : -q;
    return q > W_MAX ? W_MAX : q;
  endfunction

  function automatic wide_t floor_root(wide_t v);
    wide_t rem, root, trial;
    rem = 0;
    root = 0;
    for (int i = 32; i >= 0; i--) begin
      rem = (rem <<< 2) | ((v >>> (2 * i)) & 3);
      root = root <<< 1;
      trial = (root <<< 1) | 1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = root | 1;
      end
    end
    return root;
  endfunction

  function automatic wide_t clamp_tiny(wide_t a);
    wide_t eps;
    eps = ((wide_t'(1) <<< FRAC) + 50000) / 100000;
    if (eps < 1) eps = 1;
    return (a > -eps && a < eps) ? eps : a;
  endfunction

  function automatic constraint_t constraint_predict(logic [1:0] func, logic signed [31:0] cx,
                                                     logic signed [31:0] cy,
                                                     logic signed [31:0] off);
    constraint_t r;
    wide_t px, py, w, xl, xr, dx, dy, d, a1, a2, b, yl, yr;
    logic deg, line;
    px = pose_x_q;
    py = pose_y_q;
    w = (wide_t'(poly_rng_q) * wide_t'(SQRT2_Q30) + (wide_t'(1) <<< 29)) >>> 30;
    xl = sat_q(px - w);
    xr = sat_q(px + w);
    deg = 1'b0;
    line = 1'b0;
    a1 = 0; a2 = 0; b = 0; d = 0;
    r = '{default: '0};
    if (func == FUNC_SAMPLE || func == FUNC_MEAN) begin
      dx = wide_t'(cx) - px;
      dy = wide_t'(cy) - py;
      d = floor_root(dx * dx + dy * dy);
      r.distance = d > W_MAX ? 31'h7fffffff : d[30:0];
    end
    if (func == FUNC_SAMPLE) begin
      a1 = div_sat(dx <<< FRAC, d, deg);
      a2 = div_sat(dy <<< FRAC, d, deg);
      b = sat_q(((a1 * cx + a2 * cy) >>> FRAC) - off);
      line = 1'b1;
    end else if (func == FUNC_HALFSPACE) begin
      a1 = clamp_tiny(cx);
      a2 = clamp_tiny(cy);
      b = off;
      line = 1'b1;
    end else if (func == FUNC_MEAN) begin
      r.active = d <= wide_t'(act_rng_q);
    end else begin
      r.distance = '0;
    end
    if (line) begin
      yl = div_sat((b <<< FRAC) - a1 * xl, a2, deg);
      yr = div_sat((b <<< FRAC) - a1 * xr, a2, deg);
      r.yl = yl[31:0];
      r.yr = yr[31:0];
      r.top = a2 > 0;
    end
    r.a1 = a1[31:0];
    r.a2 = a2[31:0];
    r.b = b[31:0];
    r.deg = deg;
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] exp);
    n_errors++;
    if (n_errors <= 20)
      $display("mismatch on result %0d, %s: got %h expected %h", n_checked, field, got, exp);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    constraint_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        e = pending_results.pop_front();
        if (out_ch.coef_a1 !== e.a1) report_mismatch("coef_a1", out_ch.coef_a1, e.a1);
        if (out_ch.coef_a2 !== e.a2) report_mismatch("coef_a2", out_ch.coef_a2, e.a2);
        if (out_ch.offset_b !== e.b) report_mismatch("offset_b", out_ch.offset_b, e.b);
        if (out_ch.dist_out !== e.distance)
          report_mismatch("dist_out", out_ch.dist_out, e.distance);
        if (out_ch.y_at_left !== e.yl) report_mismatch("y_at_left", out_ch.y_at_left, e.yl);
        if (out_ch.y_at_right !== e.yr)
          report_mismatch("y_at_right", out_ch.y_at_right, e.yr);
        if (out_ch.is_top !== e.top) report_mismatch("is_top", out_ch.is_top, e.top);
        if (out_ch.is_active !== e.active)
          report_mismatch("is_active", out_ch.is_active, e.active);
        if (out_ch.degenerate !== e.deg)
          report_mismatch("degenerate", out_ch.degenerate, e.deg);
        if (e.deg) n_degenerate++;
        if (e.active) n_active++;
      end
      n_checked++;
    end
  end

  task automatic send_item(logic [1:0] func, logic signed [31:0] cx, logic signed [31:0] cy,
                           logic signed [31:0] off);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.func      <= func;
    in_ch.coord_x   <= cx;
    in_ch.coord_y   <= cy;
    in_ch.offset_in <= off;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(constraint_predict(func, cx, cy, off));
    n_sent++;
  endtask

  task automatic drain;
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_POSE_X:   pose_x_q = value;
      CFG_POSE_Y:   pose_y_q = value;
      CFG_POLY_RNG: poly_rng_q = value[30:0];
      default:      act_rng_q = value[30:0];
    endcase
    @(posedge clk);
  endtask

  task automatic set_stage(logic [31:0] px, logic [31:0] py, logic [30:0] poly,
                           logic [30:0] act);
    write_reg(CFG_POSE_X, px);
    write_reg(CFG_POSE_Y, py);
    write_reg(CFG_POLY_RNG, {1'b0, poly});
    write_reg(CFG_ACT_RNG, {1'b0, act});
  endtask

  function automatic logic [31:0] near_coord(logic [31:0] base);
    case ($urandom_range(3))
      0:       return $urandom;
      1:       return base + $urandom_range(2621440) - 1310720;
      2:       return base + $urandom_range(64) - 32;
      default: return base + $urandom_range(131072000) - 65536000;
    endcase
  endfunction

  function automatic logic [30:0] rand_range();
    case ($urandom_range(4))
      0:       return 31'h7fffffff;
      1:       return '0;
      2:       return $urandom;
      default: return $urandom_range(1310720);
    endcase
  endfunction

  task automatic test_reset_values;
    send_item(FUNC_SAMPLE, 32'sd65536, 32'sd65536, 32'sd32768);
    send_item(FUNC_MEAN, 32'sd655360, 32'sd0, 32'sd0);
    send_item(FUNC_MEAN, 32'sd655361, 32'sd0, 32'sd0);
    send_item(FUNC_HALFSPACE, 32'sd65536, -32'sd65536, 32'sd100);
    drain();
  endtask

  task automatic test_special_cases;
    set_stage(32'sd131072, -32'sd65536, 31'd327680, 31'd655360);
    // sample on the pose: zero distance
    send_item(FUNC_SAMPLE, 32'sd131072, -32'sd65536, 32'sd65536);
    // horizontal offset: a2 is zero
    send_item(FUNC_SAMPLE, 32'sd262144, -32'sd65536, 32'sd0);
    send_item(FUNC_SAMPLE, 32'sd0, -32'sd65536, -32'sd5);
    // tiny and zero external coefficients
    send_item(FUNC_HALFSPACE, 32'sd0, 32'sd0, 32'sd0);
    send_item(FUNC_HALFSPACE, 32'sd0, 32'sd0, 32'sd7);
    send_item(FUNC_HALFSPACE, -32'sd1, 32'sd1, -32'sd7);
    send_item(FUNC_HALFSPACE, 32'sd65536, -32'sd2, 32'sd100);
    send_item(FUNC_MEAN, 32'sd131072, -32'sd65536, 32'sd0);
    send_item(2'd3, -32'sd1, 32'sd12345, 32'sd99);
    drain();
  endtask

  task automatic test_extremes;
    set_stage(32'h7fffffff, 32'h80000000, 31'h7fffffff, 31'd0);
    send_item(FUNC_SAMPLE, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff);
    send_item(FUNC_SAMPLE, 32'sh7fffffff, 32'sh80000000, 32'sh80000000);
    send_item(FUNC_HALFSPACE, 32'sh80000000, 32'sh80000000, 32'sh7fffffff);
    send_item(FUNC_HALFSPACE, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000);
    send_item(FUNC_MEAN, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff);
    send_item(FUNC_MEAN, 32'sh7fffffff, 32'sh80000000, 32'sh0);
    drain();
    set_stage(32'h80000000, 32'h7fffffff, 31'd0, 31'h7fffffff);
    send_item(FUNC_SAMPLE, 32'sh7fffffff, 32'sh80000000, 32'sh80000000);
    send_item(FUNC_HALFSPACE, 32'sh0, 32'sh7fffffff, 32'sh7fffffff);
    send_item(FUNC_MEAN, 32'sh7fffffff, 32'sh80000000, 32'sh0);
    drain();
  endtask

  task automatic test_random_stages;
    logic [1:0] func;
    for (int stage = 0; stage < 12; stage++) begin
      if (stage == 4) begin
        src_idle_pct = 46;
        snk_idle_pct = 25;
      end else if (stage == 8) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      set_stage($urandom_range(3) == 0 ? $urandom : $urandom_range(6553600) - 3276800,
                $urandom_range(3) == 0 ? $urandom : $urandom_range(6553600) - 3276800,
                rand_range(), rand_range());
      for (int k = 0; k < 117; k++) begin
        func = $urandom_range(19) == 0 ? 2'd3 : 2'($urandom_range(2));
        send_item(func, near_coord(pose_x_q), near_coord(pose_y_q),
                  $urandom_range(1) ? $urandom : $urandom_range(262144));
        // hold off once mid-stage until the pipeline has emptied
        if (stage == 2 && k == 50) drain();
      end
      drain();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.func = '0;
    in_ch.coord_x = '0;
    in_ch.coord_y = '0;
    in_ch.offset_in = '0;
    pose_x_q = '0;
    pose_y_q = '0;
    poly_rng_q = POLY_RNG_RST;
    act_rng_q = ACT_RNG_RST;
    src_idle_pct = 25;
    snk_idle_pct = 46;
    n_errors = 0;
    n_sent = 0;
    n_checked = 0;
    n_degenerate = 0;
    n_active = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_special_cases();
    test_extremes();
    test_random_stages();
    $display("covered %0d items over 16 register settings, %0d results checked",
             n_sent, n_checked);
    $display("%0d degenerate results, %0d active obstacle means", n_degenerate, n_active);
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/shc_pkg.sv
src/shc_if.sv
src/shc_sqrt_pipe.sv
src/shc_div_pipe.sv
src/sample_halfspace_constraint_gen.sv
verif/tb.sv
